// File: sv/sgi_pkg.sv
// ----------------------------------------------------------------------------
// sgi_pkg
// Shared types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sgi_pkg;

  // Per-item control that travels beside the arithmetic payload
  typedef struct packed {
    logic valid;
    logic hit;
    logic pvalid;
  } sgi_flags_t;

endpackage

// File: sv/sgi_front.sv
// ----------------------------------------------------------------------------
// sgi_front
// Differences, cross products and orientation classification (four stages).
// ----------------------------------------------------------------------------
module sgi_front #(
  parameter int W = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [W-1:0]        ax_i,
  input  logic signed [W-1:0]        ay_i,
  input  logic signed [W-1:0]        bx_i,
  input  logic signed [W-1:0]        by_i,
  input  logic signed [W-1:0]        cx_i,
  input  logic signed [W-1:0]        cy_i,
  input  logic signed [W-1:0]        dx_i,
  input  logic signed [W-1:0]        dy_i,
  output sgi_pkg::sgi_flags_t        flags_o,
  output logic signed [2*W+2:0]      num_o,
  output logic signed [2*W+2:0]      den_o,
  output logic signed [W:0]          rx_o,
  output logic signed [W:0]          ry_o,
  output logic signed [W-1:0]        ax_o,
  output logic signed [W-1:0]        ay_o
);
  import sgi_pkg::*;

  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int CW = 2 * W + 3;

  function automatic logic between(input logic signed [W-1:0] e0,
                                   input logic signed [W-1:0] e1,
                                   input logic signed [W-1:0] v);
    between = ((v >= e0) && (v <= e1)) || ((v >= e1) && (v <= e0));
  endfunction

  function automatic logic signed [DW-1:0] sub(input logic signed [W-1:0] p,
                                               input logic signed [W-1:0] q);
    sub = $signed({p[W-1], p}) - $signed({q[W-1], q});
  endfunction

  // {negative, nonzero}
  function automatic logic [1:0] sgn(input logic signed [CW-1:0] v);
    sgn = {v[CW-1], v != '0};
  endfunction

  // stage 1: edge vectors and bounding-box tests
  logic                 v1_q;
  logic signed [W-1:0]  ax1_q, ay1_q;
  logic signed [DW-1:0] bax_q, bay_q, cax_q, cay_q, dax_q, day_q;
  logic signed [DW-1:0] dcx_q, dcy_q, acx_q, acy_q, bcx_q, bcy_q;
  logic [3:0]           seg1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q  <= ax_i;
      ay1_q  <= ay_i;
      bax_q  <= sub(bx_i, ax_i);
      bay_q  <= sub(by_i, ay_i);
      cax_q  <= sub(cx_i, ax_i);
      cay_q  <= sub(cy_i, ay_i);
      dax_q  <= sub(dx_i, ax_i);
      day_q  <= sub(dy_i, ay_i);
      dcx_q  <= sub(dx_i, cx_i);
      dcy_q  <= sub(dy_i, cy_i);
      acx_q  <= sub(ax_i, cx_i);
      acy_q  <= sub(ay_i, cy_i);
      bcx_q  <= sub(bx_i, cx_i);
      bcy_q  <= sub(by_i, cy_i);
      seg1_q <= {between(cx_i, dx_i, bx_i) && between(cy_i, dy_i, by_i),
                 between(cx_i, dx_i, ax_i) && between(cy_i, dy_i, ay_i),
                 between(ax_i, bx_i, dx_i) && between(ay_i, by_i, dy_i),
                 between(ax_i, bx_i, cx_i) && between(ay_i, by_i, cy_i)};
    end
  end

  // stage 2: products
  logic                 v2_q;
  logic signed [W-1:0]  ax2_q, ay2_q;
  logic signed [DW-1:0] rx2_q, ry2_q;
  logic [3:0]           seg2_q;
  logic signed [PW-1:0] p1a_q, p1b_q, p2a_q, p2b_q, p3a_q, p3b_q, p4a_q, p4b_q;
  logic signed [PW-1:0] pda_q, pdb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      rx2_q  <= bax_q;
      ry2_q  <= bay_q;
      seg2_q <= seg1_q;
      p1a_q  <= bax_q * cay_q;
      p1b_q  <= bay_q * cax_q;
      p2a_q  <= bax_q * day_q;
      p2b_q  <= bay_q * dax_q;
      p3a_q  <= dcx_q * acy_q;
      p3b_q  <= dcy_q * acx_q;
      p4a_q  <= dcx_q * bcy_q;
      p4b_q  <= dcy_q * bcx_q;
      pda_q  <= bax_q * dcy_q;
      pdb_q  <= bay_q * dcx_q;
    end
  end

  // stage 3: cross products
  logic                 v3_q;
  logic signed [W-1:0]  ax3_q, ay3_q;
  logic signed [DW-1:0] rx3_q, ry3_q;
  logic [3:0]           seg3_q;
  logic signed [CW-1:0] c1_q, c2_q, c3_q, c4_q, cd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      rx3_q  <= rx2_q;
      ry3_q  <= ry2_q;
      seg3_q <= seg2_q;
      c1_q   <= $signed({p1a_q[PW-1], p1a_q}) - $signed({p1b_q[PW-1], p1b_q});
      c2_q   <= $signed({p2a_q[PW-1], p2a_q}) - $signed({p2b_q[PW-1], p2b_q});
      c3_q   <= $signed({p3a_q[PW-1], p3a_q}) - $signed({p3b_q[PW-1], p3b_q});
      c4_q   <= $signed({p4a_q[PW-1], p4a_q}) - $signed({p4b_q[PW-1], p4b_q});
      cd_q   <= $signed({pda_q[PW-1], pda_q}) - $signed({pdb_q[PW-1], pdb_q});
    end
  end

  // stage 4: classify
  logic [1:0] o1, o2, o3, o4;
  logic       hit;
  sgi_flags_t flags_d, flags_q;
  logic signed [CW-1:0] num_q, den_q;
  logic signed [DW-1:0] rx4_q, ry4_q;
  logic signed [W-1:0]  ax4_q, ay4_q;

  always_comb begin
    o1  = sgn(c1_q);
    o2  = sgn(c2_q);
    o3  = sgn(c3_q);
    o4  = sgn(c4_q);
    hit = ((o1 != o2) && (o3 != o4))
       || (!o1[0] && seg3_q[0]) || (!o2[0] && seg3_q[1])
       || (!o3[0] && seg3_q[2]) || (!o4[0] && seg3_q[3]);
    flags_d.valid  = v3_q;
    flags_d.hit    = hit;
    flags_d.pvalid = hit && (cd_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_d;
    end
  end

  // the numerator of t is the third orientation cross product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= c3_q;
      den_q <= cd_q;
      rx4_q <= rx3_q;
      ry4_q <= ry3_q;
      ax4_q <= ax3_q;
      ay4_q <= ay3_q;
    end
  end

  assign flags_o = flags_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign rx_o    = rx4_q;
  assign ry_o    = ry4_q;
  assign ax_o    = ax4_q;
  assign ay_o    = ay4_q;

endmodule

// File: sv/sgi_scale.sv
// ----------------------------------------------------------------------------
// sgi_scale
// Forms num*delta in two partial products, then magnitudes and quotient signs.
// ----------------------------------------------------------------------------
module sgi_scale #(
  parameter int W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  sgi_pkg::sgi_flags_t   flags_i,
  input  logic signed [2*W+2:0] num_i,
  input  logic signed [2*W+2:0] den_i,
  input  logic signed [W:0]     rx_i,
  input  logic signed [W:0]     ry_i,
  input  logic signed [W-1:0]   ax_i,
  input  logic signed [W-1:0]   ay_i,
  output sgi_pkg::sgi_flags_t   flags_o,
  output logic [3*W+3:0]        nx_o,
  output logic [3*W+3:0]        ny_o,
  output logic [2*W+2:0]        dmag_o,
  output logic                  negx_o,
  output logic                  negy_o,
  output logic signed [W-1:0]   ax_o,
  output logic signed [W-1:0]   ay_o
);
  import sgi_pkg::*;

  localparam int CW  = 2 * W + 3;
  localparam int NLW = W + 2;
  localparam int NHW = CW - NLW;
  localparam int PW  = 2 * W + 2;
  localparam int LPW = 2 * W + 4;
  localparam int MW  = 3 * W + 4;

  logic signed [NLW:0]   num_lo;
  logic signed [NHW-1:0] num_hi;

  assign num_lo = $signed({1'b0, num_i[NLW-1:0]});
  assign num_hi = num_i[CW-1:NLW];

  // stage 5: partial products
  sgi_flags_t            f5_q;
  logic signed [LPW-1:0] lox_q, loy_q;
  logic signed [PW-1:0]  hix_q, hiy_q;
  logic signed [CW-1:0]  den5_q;
  logic signed [W-1:0]   ax5_q, ay5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f5_q <= '0;
    end else if (en_i) begin
      f5_q <= flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lox_q  <= num_lo * rx_i;
      loy_q  <= num_lo * ry_i;
      hix_q  <= num_hi * rx_i;
      hiy_q  <= num_hi * ry_i;
      den5_q <= den_i;
      ax5_q  <= ax_i;
      ay5_q  <= ay_i;
    end
  end

  // stage 6: recombine
  sgi_flags_t           f6_q;
  logic signed [MW-1:0] prx_q, pry_q;
  logic signed [CW-1:0] den6_q;
  logic signed [W-1:0]  ax6_q, ay6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f6_q <= '0;
    end else if (en_i) begin
      f6_q <= f5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prx_q  <= ($signed({{(MW-PW){hix_q[PW-1]}}, hix_q}) <<< NLW)
              + $signed({{(MW-LPW){lox_q[LPW-1]}}, lox_q});
      pry_q  <= ($signed({{(MW-PW){hiy_q[PW-1]}}, hiy_q}) <<< NLW)
              + $signed({{(MW-LPW){loy_q[LPW-1]}}, loy_q});
      den6_q <= den5_q;
      ax6_q  <= ax5_q;
      ay6_q  <= ay5_q;
    end
  end

  // stage 7: magnitudes for the unsigned divider
  sgi_flags_t          f7_q;
  logic [MW-1:0]       nx_q, ny_q;
  logic [CW-1:0]       dmag_q;
  logic                negx_q, negy_q;
  logic signed [W-1:0] ax7_q, ay7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f7_q <= '0;
    end else if (en_i) begin
      f7_q <= f6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q   <= prx_q[MW-1] ? MW'(-prx_q) : MW'(prx_q);
      ny_q   <= pry_q[MW-1] ? MW'(-pry_q) : MW'(pry_q);
      dmag_q <= den6_q[CW-1] ? CW'(-den6_q) : CW'(den6_q);
      negx_q <= prx_q[MW-1] ^ den6_q[CW-1];
      negy_q <= pry_q[MW-1] ^ den6_q[CW-1];
      ax7_q  <= ax6_q;
      ay7_q  <= ay6_q;
    end
  end

  assign flags_o = f7_q;
  assign nx_o    = nx_q;
  assign ny_o    = ny_q;
  assign dmag_o  = dmag_q;
  assign negx_o  = negx_q;
  assign negy_o  = negy_q;
  assign ax_o    = ax7_q;
  assign ay_o    = ay7_q;

endmodule

// File: sv/sgi_div.sv
// ----------------------------------------------------------------------------
// sgi_div
// Pipelined restoring divider, one quotient bit per stage, signed result.
// ----------------------------------------------------------------------------
module sgi_div #(
  parameter int W  = 32,
  parameter int SW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [3*W+3:0] num_i,
  input  logic [2*W+2:0] den_i,
  input  logic           neg_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [W-1:0]   quo_o,
  output logic [SW-1:0]  side_o
);
  import sgi_pkg::*;

  localparam int Q  = W + 1;
  localparam int MW = 3 * W + 4;
  localparam int CW = 2 * W + 3;
  localparam int RW = CW + 1;

  logic          v_q    [Q+1];
  logic [RW-1:0] rem_q  [Q+1];
  logic [Q-1:0]  low_q  [Q+1];
  logic [Q-1:0]  quo_q  [Q+1];
  logic [CW-1:0] den_q  [Q+1];
  logic          neg_q  [Q+1];
  logic [SW-1:0] side_q [Q+1];

  // entry stage: the quotient fits Q bits, so the top bits seed the remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= RW'(num_i[MW-1:Q]);
      low_q[0]  <= num_i[Q-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      neg_q[0]  <= neg_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < Q; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = {rem_q[k][RW-2:0], low_q[k][Q-1]};
    assign ge    = trial >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? trial - {1'b0, den_q[k]} : trial;
        low_q[k+1]  <= {low_q[k][Q-2:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][Q-2:0], ge};
        den_q[k+1]  <= den_q[k];
        neg_q[k+1]  <= neg_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  logic [Q-1:0] quo_neg;
  assign quo_neg = ~quo_q[Q] + Q'(1);

  assign valid_o = v_q[Q];
  assign quo_o   = neg_q[Q] ? quo_neg[W-1:0] : quo_q[Q][W-1:0];
  assign side_o  = side_q[Q];

endmodule

// File: sv/segment_intersection_unit.sv
// ----------------------------------------------------------------------------
// segment_intersection_unit
// Closed 2D segment intersection test with exact intersection point.
// ----------------------------------------------------------------------------
// One segment pair enters per cycle while the pipeline advances, and its
// result passes through four stages of differences, products and
// orientation tests, three stages that form num*delta and its magnitude,
// COORD_WIDTH+2 stages of the bit-per-stage divider that sets the depth,
// and the output register. The pipeline advances whenever the output
// register is empty or its item is being taken, so a held result stalls the
// whole pipeline and nothing is lost or repeated. Parallel or collinear but
// touching pairs report intersects with point_valid low; the point is zero
// whenever point_valid is low.
module segment_intersection_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_coord_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] dx_i,
  input  logic signed [COORD_WIDTH-1:0] dy_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          intersects_o,
  output logic                          point_valid_o,
  output logic signed [COORD_WIDTH-1:0] px_o,
  output logic signed [COORD_WIDTH-1:0] py_o
);
  import sgi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int CW = 2 * W + 3;
  localparam int MW = 3 * W + 4;

  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  sgi_flags_t           fr_flags;
  logic signed [CW-1:0] fr_num, fr_den;
  logic signed [W:0]    fr_rx, fr_ry;
  logic signed [W-1:0]  fr_ax, fr_ay;

  sgi_front #(.W(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .ax_i    (ax_i),
    .ay_i    (ay_i),
    .bx_i    (bx_i),
    .by_i    (by_coord_i),
    .cx_i    (cx_i),
    .cy_i    (cy_i),
    .dx_i    (dx_i),
    .dy_i    (dy_i),
    .flags_o (fr_flags),
    .num_o   (fr_num),
    .den_o   (fr_den),
    .rx_o    (fr_rx),
    .ry_o    (fr_ry),
    .ax_o    (fr_ax),
    .ay_o    (fr_ay)
  );

  sgi_flags_t          sc_flags;
  logic [MW-1:0]       sc_nx, sc_ny;
  logic [CW-1:0]       sc_dmag;
  logic                sc_negx, sc_negy;
  logic signed [W-1:0] sc_ax, sc_ay;

  sgi_scale #(.W(W)) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .flags_i (fr_flags),
    .num_i   (fr_num),
    .den_i   (fr_den),
    .rx_i    (fr_rx),
    .ry_i    (fr_ry),
    .ax_i    (fr_ax),
    .ay_i    (fr_ay),
    .flags_o (sc_flags),
    .nx_o    (sc_nx),
    .ny_o    (sc_ny),
    .dmag_o  (sc_dmag),
    .negx_o  (sc_negx),
    .negy_o  (sc_negy),
    .ax_o    (sc_ax),
    .ay_o    (sc_ay)
  );

  logic             dvx_valid, dvy_valid;
  logic [W-1:0]     qx, qy;
  logic [W+1:0]     sidex;
  logic [W-1:0]     sidey;

  sgi_div #(.W(W), .SW(W + 2)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sc_flags.valid),
    .num_i   (sc_nx),
    .den_i   (sc_dmag),
    .neg_i   (sc_negx),
    .side_i  ({sc_flags.hit, sc_flags.pvalid, sc_ax}),
    .valid_o (dvx_valid),
    .quo_o   (qx),
    .side_o  (sidex)
  );

  sgi_div #(.W(W), .SW(W)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sc_flags.valid),
    .num_i   (sc_ny),
    .den_i   (sc_dmag),
    .neg_i   (sc_negy),
    .side_i  (sc_ay),
    .valid_o (dvy_valid),
    .quo_o   (qy),
    .side_o  (sidey)
  );

  logic         hit_s, pv_s;
  logic [W-1:0] ax_s;

  assign hit_s = sidex[W+1];
  assign pv_s  = sidex[W];
  assign ax_s  = sidex[W-1:0];

  // output register
  logic         intersects_q, point_valid_q;
  logic [W-1:0] px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dvx_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      intersects_q  <= hit_s;
      point_valid_q <= pv_s;
      px_q          <= pv_s ? ax_s + qx : '0;
      py_q          <= pv_s ? sidey + qy : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign intersects_o  = intersects_q;
  assign point_valid_o = point_valid_q;
  assign px_o          = px_q;
  assign py_o          = py_q;

  // both divider lanes carry the same items
  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvx_valid == dvy_valid)
    else $error("divider lanes out of step");

  a_pv_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && point_valid_o |-> intersects_o)
    else $error("point valid without intersection");

  a_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_valid_o |-> (px_o == '0) && (py_o == '0))
    else $error("nonzero point while not valid");

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for segment_intersection_unit. Drives segment pairs and checks
// the intersect flag, the point flag and the point against an exact
// integer predictor, with random idling on both the input and output sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W     = 32;
  localparam int LAT   = W + 10;
  localparam int LIMIT = 400000;

  typedef logic signed [W-1:0] coord_t;
  typedef logic signed [W+3:0] diff_t;
  typedef logic signed [2*W+7:0] prod_t;
  typedef logic signed [4*W+15:0] big_t;

  typedef struct {
    logic   hit;
    logic   pvalid;
    coord_t px;
    coord_t py;
  } isect_t;

  logic   clk, rst_n;
  logic   in_valid, in_ready, out_valid, out_ready;
  coord_t ax, ay, bx, by, cx, cy, dx, dy;
  logic   hit_o, pvalid_o;
  coord_t px_o, py_o;

  isect_t pending_q[$];
  int     errors, n_items, n_hits, n_points, cycles;
  bit     quiet;

  segment_intersection_unit #(.COORD_WIDTH(W)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .ax_i(ax), .ay_i(ay), .bx_i(bx), .by_coord_i(by),
    .cx_i(cx), .cy_i(cy), .dx_i(dx), .dy_i(dy),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .intersects_o(hit_o), .point_valid_o(pvalid_o), .px_o(px_o), .py_o(py_o)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int orient_sign(coord_t pxv, coord_t pyv, coord_t qx,
                                     coord_t qy, coord_t rx, coord_t ry);
    prod_t c;
    c = prod_t'(diff_t'(qx) - diff_t'(pxv)) * prod_t'(diff_t'(ry) - diff_t'(pyv))
      - prod_t'(diff_t'(qy) - diff_t'(pyv)) * prod_t'(diff_t'(rx) - diff_t'(pxv));
    return (c < 0) ? -1 : (c > 0) ? 1 : 0;
  endfunction

  function automatic bit within_box(coord_t p0x, coord_t p0y, coord_t p1x,
                                    coord_t p1y, coord_t rx, coord_t ry);
    coord_t lx, hx, ly, hy;
    lx = (p0x < p1x) ? p0x : p1x;
    hx = (p0x < p1x) ? p1x : p0x;
    ly = (p0y < p1y) ? p0y : p1y;
    hy = (p0y < p1y) ? p1y : p0y;
    return rx >= lx && rx <= hx && ry >= ly && ry <= hy;
  endfunction

  function automatic isect_t segment_crossing();
    isect_t r;
    int     o1, o2, o3, o4;
    prod_t  den, num;
    big_t   qx, qy;
    diff_t  rx, ry, sx, sy;
    r  = '{1'b0, 1'b0, '0, '0};
    o1 = orient_sign(ax, ay, bx, by, cx, cy);
    o2 = orient_sign(ax, ay, bx, by, dx, dy);
    o3 = orient_sign(cx, cy, dx, dy, ax, ay);
    o4 = orient_sign(cx, cy, dx, dy, bx, by);
    r.hit = (o1 != o2 && o3 != o4)
         || (o1 == 0 && within_box(ax, ay, bx, by, cx, cy))
         || (o2 == 0 && within_box(ax, ay, bx, by, dx, dy))
         || (o3 == 0 && within_box(cx, cy, dx, dy, ax, ay))
         || (o4 == 0 && within_box(cx, cy, dx, dy, bx, by));
    if (r.hit) begin
      rx  = diff_t'(bx) - diff_t'(ax);
      ry  = diff_t'(by) - diff_t'(ay);
      sx  = diff_t'(dx) - diff_t'(cx);
      sy  = diff_t'(dy) - diff_t'(cy);
      den = prod_t'(rx) * prod_t'(sy) - prod_t'(ry) * prod_t'(sx);
      if (den != 0) begin
        num = prod_t'(diff_t'(cx) - diff_t'(ax)) * prod_t'(sy)
            - prod_t'(diff_t'(cy) - diff_t'(ay)) * prod_t'(sx);
        // SV signed division truncates toward zero
        qx = (big_t'(num) * big_t'(rx)) / big_t'(den);
        qy = (big_t'(num) * big_t'(ry)) / big_t'(den);
        r.px = ax + coord_t'(qx);
        r.py = ay + coord_t'(qy);
        r.pvalid = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic send_pair(coord_t a0, coord_t a1, coord_t b0, coord_t b1,
                           coord_t c0, coord_t c1, coord_t d0, coord_t d1);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    ax <= a0; ay <= a1; bx <= b0; by <= b1;
    cx <= c0; cy <= c1; dx <= d0; dy <= d1;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Predict on acceptance, from the held payload
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      pending_q.push_back(segment_crossing());
      n_items++;
    end
  end

  always @(posedge clk) begin
    isect_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %0b %0b %0d %0d",
                 $time, hit_o, pvalid_o, px_o, py_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (e.hit) n_hits++;
        if (e.pvalid) n_points++;
        if (hit_o !== e.hit || pvalid_o !== e.pvalid || px_o !== e.px ||
            py_o !== e.py) begin
          $display("%0t: expected hit=%0b pv=%0b p=(%0d,%0d) got hit=%0b pv=%0b p=(%0d,%0d)",
                   $time, e.hit, e.pvalid, e.px, e.py, hit_o, pvalid_o, px_o, py_o);
          errors++;
        end
      end
    end
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(40)) - 20;
      default: return coord_t'($signed($urandom) >>> $urandom_range(20));
    endcase
  endfunction

  task automatic test_extremes();
    coord_t mx, mn;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    send_pair(mn, mn, mx, mx, mn, mx, mx, mn);
    send_pair(mx, mn, mn, mx, mn, mn, mx, mx);
    send_pair(mn, mn, mx, mn, mn, mx, mx, mx);
    send_pair(mn, 0, mx, 0, 0, mn, 0, mx);
    send_pair(-1, -1, -1, -1, -1, -1, -1, -1);
    send_pair(mx, mx, mx, mx, mn, mn, mn, mn);
  endtask

  task automatic test_special_cases();
    send_pair(0, 0, 4, 4, 0, 4, 4, 0);       // proper crossing
    send_pair(0, 0, 4, 0, 2, 0, 2, 5);       // endpoint touching the other segment
    send_pair(0, 0, 4, 0, 4, 0, 8, 3);       // shared endpoint
    send_pair(0, 0, 4, 0, 2, 0, 6, 0);       // collinear overlap
    send_pair(0, 0, 4, 0, 5, 0, 8, 0);       // collinear disjoint
    send_pair(0, 0, 4, 0, 0, 1, 4, 1);       // parallel apart
    send_pair(0, 0, 4, 4, 5, 0, 9, 3);       // no touch
    send_pair(2, 2, 2, 2, 0, 0, 4, 4);       // point on segment
    send_pair(2, 3, 2, 3, 0, 0, 4, 4);       // point off segment
    send_pair(1, 1, 1, 1, 1, 1, 1, 1);       // two equal points
    send_pair(0, 0, 7, 3, 1, 5, 6, -4);      // truncated point
    send_pair(0, 0, -7, -3, -1, -5, -6, 4);
    send_pair(32'h10000, 0, 0, 32'h30000, 0, 0, 32'h20000, 32'h20000);
  endtask

  task automatic test_random(int count);
    coord_t v[8];
    int     mode;
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 2 && i < count / 2 + 200);
      mode  = $urandom_range(5);
      foreach (v[k]) v[k] = rand_coord(mode % 3);
      if (mode == 3) begin
        // put C on segment A-B, at its midpoint, so touching and collinear cases occur
        v[2] = v[0] + 2 * (rand_coord(1));
        v[3] = v[1] + 2 * (rand_coord(1));
        v[4] = (v[0] + v[2]) >>> 1;
        v[5] = (v[1] + v[3]) >>> 1;
      end else if (mode == 4) begin
        // crossing pair around a shared midpoint
        v[2] = 2 * v[0] - rand_coord(1) + 0;
        v[4] = v[0] + rand_coord(1);
        v[5] = v[1] + rand_coord(1);
        v[6] = 2 * v[0] - v[4];
        v[7] = 2 * v[1] - v[5];
        v[2] = 2 * v[0] - v[2];
        v[3] = 2 * v[1] - v[1] + rand_coord(1);
        v[0] = 2 * v[0] - v[2];
        v[1] = 2 * v[1] - v[3];
      end
      send_pair(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0; quiet = 1'b0;
    {ax, ay, bx, by, cx, cy, dx, dy} = '0;
    errors = 0; n_items = 0; n_hits = 0; n_points = 0; cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_special_cases();
    test_random(1800);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    $display("Covered %0d segment pairs: %0d touching or crossing, %0d with a point.",
             n_items, n_hits, n_points);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: segment_intersection_unit.f
sv/sgi_pkg.sv
sv/sgi_front.sv
sv/sgi_scale.sv
sv/sgi_div.sv
sv/segment_intersection_unit.sv
sim/tb.sv
